[src/aging_priority_job_queue_macros.svh]
// Assertion macros shared by the job queue modules.
`ifndef AGING_PRIORITY_JOB_QUEUE_MACROS_SVH
`define AGING_PRIORITY_JOB_QUEUE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define APQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define APQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/apjq_pkg.sv]
// Package for the aging priority job queue: types, codes and helpers.
package apjq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRI_LEVELS_DEF = 4;
	localparam logic [31:0] AGE_LIMIT_RST = 32'd60;

	typedef enum logic [2:0] {
		ACT_ENQ = 3'd0,
		ACT_DEQ = 3'd1,
		ACT_DEL = 3'd2,
		ACT_CLR = 3'd3,
		ACT_AGE = 3'd4
	} action_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOPERM = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_BADPOS = 3'd4;

	localparam logic [1:0] ROLE_NORMAL = 2'd0;
	localparam logic [1:0] ROLE_ADMIN = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [31:0] now_time;
		logic [15:0] job_tag;
		logic [15:0] page_count;
		logic [1:0] job_priority;
		logic [1:0] user_role;
		logic [4:0] position;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic job_valid;
		logic [15:0] out_tag;
		logic [15:0] out_pages;
		logic [1:0] out_priority;
		logic [1:0] out_role;
		logic [31:0] out_time;
		logic [4:0] job_count;
	} out_item_t;

	// One queued job.
	typedef struct packed {
		logic [31:0] t;
		logic [15:0] tag;
		logic [15:0] pages;
		logic [1:0] pri;
		logic [1:0] role;
	} job_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SORT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic sort_even;
		logic sort_odd;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_age;
		logic sort_done;
	} dp_sts_t;

	// (a) strictly ahead of (b): lower priority number, then earlier time
	function automatic logic goes_before(job_t a, job_t b);
		if (a.pri != b.pri)
			return a.pri < b.pri;
		return a.t < b.t;
	endfunction

endpackage

[src/apjq_ctrl.sv]
// Controller state machine of the job queue.
module apjq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input apjq_pkg::dp_sts_t sts,
	output apjq_pkg::dp_cmd_t cmd,
	output logic busy
);
	import apjq_pkg::*;

	state_t state_q, state_d;
	logic phase_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_EXEC;
			S_EXEC: if (sts.is_age) state_d = S_SORT; else state_d = S_IDLE;
			S_SORT: if (sts.sort_done) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SORT) phase_q <= ~phase_q;
			else phase_q <= 1'b0;
		end
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				cmd.emit = !sts.is_age;
			end
			S_SORT: begin
				cmd.sort_even = !phase_q;
				cmd.sort_odd = phase_q;
				cmd.emit = sts.sort_done;
			end
			default: busy = 1'b1;
		endcase
	end

	`include "aging_priority_job_queue_macros.svh"
	`APQ_ASSERT_IMP(a_emit_busy, clk, arst_n, cmd.emit, busy, "emit while idle")
	`APQ_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
	`APQ_ASSERT_IMP(a_one_phase, clk, arst_n, 1'b1, !(cmd.sort_even && cmd.sort_odd),
		"two sort phases")
endmodule

[src/apjq_dp.sv]
// Datapath of the job queue: sorted register chain, aging and odd-even sort.
module apjq_dp #(
	parameter int DEPTH = apjq_pkg::DEPTH_DEF,
	parameter int PRI_LEVELS = apjq_pkg::PRI_LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input apjq_pkg::dp_cmd_t cmd,
	input apjq_pkg::in_item_t in_item,
	input logic [31:0] age_limit,
	output apjq_pkg::dp_sts_t sts,
	output apjq_pkg::out_item_t out_item,
	output logic done
);
	import apjq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [1:0] PRI_MAX = 2'(PRI_LEVELS - 1);

	job_t slot_q [DEPTH];
	logic [CW-1:0] occ_q;
	in_item_t req_q;
	logic [2:0] stat_q;
	logic vld_q;
	job_t got_q;
	logic [CW-1:0] sort_cnt_q;
	logic done_q;

	// decoded request
	logic [1:0] pri_sat;
	job_t new_job;
	logic is_full, is_empty, pos_bad;
	logic [CW-1:0] pos_w;
	logic dep_ok, sort_last;

	always_comb begin
		pri_sat = (req_q.job_priority > PRI_MAX) ? PRI_MAX : req_q.job_priority;
		new_job.t = req_q.now_time;
		new_job.tag = req_q.job_tag;
		new_job.pages = req_q.page_count;
		new_job.pri = pri_sat;
		new_job.role = req_q.user_role;
		is_full = (occ_q == CW'(DEPTH));
		is_empty = (occ_q == '0);
		pos_w = CW'(req_q.position);
		pos_bad = (req_q.position == 5'd0) || ({27'd0, req_q.position} > 32'(occ_q));
		dep_ok = !(req_q.user_role == ROLE_NORMAL && pri_sat == 2'd0) && !is_full;
		sort_last = (sort_cnt_q == CW'(DEPTH - 1));
	end

	assign sts.is_age = (req_q.action == ACT_AGE);
	assign sts.sort_done = sort_last;

	// per-cell next value
	job_t slot_d [DEPTH];
	logic gt [DEPTH];
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			slot_d[i] = slot_q[i];
			gt[i] = (CW'(i) < occ_q) && goes_before(new_job, slot_q[i]);
		end
		if (cmd.exec) begin
			unique case (req_q.action)
				ACT_ENQ: if (dep_ok) begin
					for (int i = 0; i < DEPTH; i++) begin
						if (CW'(i) == occ_q || (CW'(i) < occ_q && gt[i])) begin
							if (i > 0 && gt[(i > 0) ? i - 1 : 0])
								slot_d[i] = slot_q[(i > 0) ? i - 1 : 0];
							else
								slot_d[i] = new_job;
						end
					end
				end
				ACT_DEQ: for (int i = 0; i < DEPTH - 1; i++) slot_d[i] = slot_q[i + 1];
				ACT_DEL: if (req_q.user_role == ROLE_ADMIN && !is_empty && !pos_bad) begin
					for (int i = 0; i < DEPTH - 1; i++)
						if (CW'(i + 1) >= pos_w) slot_d[i] = slot_q[i + 1];
				end
				ACT_AGE: for (int i = 0; i < DEPTH; i++)
					if (req_q.now_time >= slot_q[i].t
							&& (req_q.now_time - slot_q[i].t) >= age_limit
							&& slot_q[i].pri != 2'd0)
						slot_d[i].pri = slot_q[i].pri - 2'd1;
				default: ;
			endcase
		end else if (cmd.sort_even || cmd.sort_odd) begin
			// compare-exchange on neighbor pairs, in the valid region only
			for (int i = 0; i < DEPTH - 1; i++) begin
				if ((i % 2 == 0) == cmd.sort_even && CW'(i + 1) < occ_q
						&& goes_before(slot_q[i + 1], slot_q[i])) begin
					slot_d[i] = slot_q[i + 1];
					slot_d[i + 1] = slot_q[i];
				end
			end
		end
	end

	// job storage and request capture
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) slot_q[i] <= slot_d[i];
		if (cmd.capture) req_q <= in_item;
	end

	// status, valid flag, occupancy, sort counter and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			stat_q <= ST_OK;
			vld_q <= 1'b0;
			sort_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.exec) begin
				sort_cnt_q <= '0;
				stat_q <= ST_OK;
				vld_q <= 1'b0;
				unique case (req_q.action)
					ACT_ENQ: begin
						if (req_q.user_role == ROLE_NORMAL && pri_sat == 2'd0)
							stat_q <= ST_NOPERM;
						else if (is_full) stat_q <= ST_FULL;
						else occ_q <= occ_q + 1'b1;
					end
					ACT_DEQ: begin
						if (is_empty) stat_q <= ST_EMPTY;
						else begin
							vld_q <= 1'b1;
							occ_q <= occ_q - 1'b1;
						end
					end
					ACT_DEL: begin
						if (req_q.user_role != ROLE_ADMIN) stat_q <= ST_NOPERM;
						else if (is_empty) stat_q <= ST_EMPTY;
						else if (pos_bad) stat_q <= ST_BADPOS;
						else occ_q <= occ_q - 1'b1;
					end
					ACT_CLR: occ_q <= '0;
					ACT_AGE: ;
					default: stat_q <= ST_NOPERM;
				endcase
			end else if (cmd.sort_even || cmd.sort_odd) begin
				sort_cnt_q <= sort_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) got_q <= slot_q[0];
	end

	// result assembled from the post-exec state, shown while done is high
	always_comb begin
		out_item.status = stat_q;
		out_item.job_valid = vld_q;
		out_item.out_tag = vld_q ? got_q.tag : 16'd0;
		out_item.out_pages = vld_q ? got_q.pages : 16'd0;
		out_item.out_priority = vld_q ? got_q.pri : 2'd0;
		out_item.out_role = vld_q ? got_q.role : 2'd0;
		out_item.out_time = vld_q ? got_q.t : 32'd0;
		out_item.job_count = 5'(occ_q);
		done = done_q;
	end

	`include "aging_priority_job_queue_macros.svh"
	`APQ_ASSERT_IMP(a_occ_range, clk, arst_n, 1'b1, occ_q <= CW'(DEPTH), "occupancy overflow")
	`APQ_ASSERT_NEXT(a_deq_count, clk, arst_n, cmd.exec && req_q.action == ACT_DEQ && !is_empty,
		occ_q == $past(occ_q) - 1'b1, "dequeue count")
	`APQ_ASSERT_NEXT(a_vld_deq, clk, arst_n, cmd.exec && req_q.action != ACT_DEQ, !vld_q,
		"job valid without dequeue")
endmodule

[src/aging_priority_job_queue.sv]
// Top level of the aging priority job queue.
// Start an item when busy is low; busy rises on the next cycle. Enqueue, dequeue,
// delete, clear and unknown actions go through the execute state and then give a
// registered result, while the next item may already start; age adds an odd-even
// transposition sort over the register chain before its result.
// Each result shows on result for one cycle with done high and cannot be stalled.
// age_limit is written on the cfg channel, always ready; the user must write it
// only while no item is in work, and the block itself does not enforce this.
module aging_priority_job_queue #(
	parameter int DEPTH = apjq_pkg::DEPTH_DEF,
	parameter int PRI_LEVELS = apjq_pkg::PRI_LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input apjq_pkg::in_item_t item,
	output logic done,
	output apjq_pkg::out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	import apjq_pkg::*;

	logic [31:0] age_limit_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) age_limit_q <= AGE_LIMIT_RST;
		else if (cfg_valid) age_limit_q <= cfg_data;
	end

	apjq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
	);

	apjq_dp #(.DEPTH(DEPTH), .PRI_LEVELS(PRI_LEVELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(item), .age_limit(age_limit_q),
		.sts(sts), .out_item(result), .done(done)
	);
endmodule

[bench/tb_aging_priority_job_queue.sv]
// Self-checking testbench for the aging priority job queue.
module tb_aging_priority_job_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import apjq_pkg::*;

	localparam int NSLOT = 16;
	localparam int NLEV = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic done;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	aging_priority_job_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	job_t q_jobs [NSLOT];
	int unsigned q_fill = 0;
	logic [31:0] aging_limit = AGE_LIMIT_RST;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int mismatches = 0;
	int idle_pct = 0;

	function automatic bit ahead(job_t a, job_t b);
		if (a.pri != b.pri) return a.pri < b.pri;
		return a.t < b.t;
	endfunction

	// compute the outcome of one item and update the predicted queue
	function automatic out_item_t apply_item(in_item_t it);
		out_item_t r;
		job_t nj, k;
		logic [1:0] pr;
		int at, j;
		r = '0;
		pr = (it.job_priority > NLEV - 1) ? 2'(NLEV - 1) : it.job_priority;
		case (it.action)
			ACT_ENQ: begin
				if (it.user_role == ROLE_NORMAL && pr == 0) r.status = ST_NOPERM;
				else if (q_fill >= NSLOT) r.status = ST_FULL;
				else begin
					nj.t = it.now_time; nj.tag = it.job_tag; nj.pages = it.page_count;
					nj.pri = pr; nj.role = it.user_role;
					at = q_fill;
					while (at > 0 && ahead(nj, q_jobs[at-1])) begin
						q_jobs[at] = q_jobs[at-1];
						at--;
					end
					q_jobs[at] = nj;
					q_fill++;
				end
			end
			ACT_DEQ: begin
				if (q_fill == 0) r.status = ST_EMPTY;
				else begin
					r.job_valid = 1'b1;
					r.out_tag = q_jobs[0].tag; r.out_pages = q_jobs[0].pages;
					r.out_priority = q_jobs[0].pri; r.out_role = q_jobs[0].role;
					r.out_time = q_jobs[0].t;
					for (int i = 1; i < q_fill; i++) q_jobs[i-1] = q_jobs[i];
					q_fill--;
				end
			end
			ACT_DEL: begin
				if (it.user_role != ROLE_ADMIN) r.status = ST_NOPERM;
				else if (q_fill == 0) r.status = ST_EMPTY;
				else if (it.position < 1 || it.position > q_fill) r.status = ST_BADPOS;
				else begin
					for (int i = it.position; i < q_fill; i++) q_jobs[i-1] = q_jobs[i];
					q_fill--;
				end
			end
			ACT_CLR: q_fill = 0;
			ACT_AGE: begin
				for (int i = 0; i < q_fill; i++)
					if (it.now_time >= q_jobs[i].t && it.now_time - q_jobs[i].t >= aging_limit
							&& q_jobs[i].pri > 0)
						q_jobs[i].pri--;
				for (int i = 1; i < q_fill; i++) begin
					k = q_jobs[i];
					j = i;
					while (j > 0 && ahead(k, q_jobs[j-1])) begin
						q_jobs[j] = q_jobs[j-1];
						j--;
					end
					q_jobs[j] = k;
				end
			end
			default: r.status = ST_NOPERM;
		endcase
		r.job_count = 5'(q_fill);
		return r;
	endfunction

	// driver: one item at a time, random gaps; a waiting item is held
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(apply_item(item));
				void'(pending_items.pop_front());
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				item <= pending_items[0];
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				e = expected_results.pop_front();
				if (result !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", e, result);
				end
			end
		end
	end

	function automatic int q_fill_bound();
		return NSLOT;
	endfunction

	function automatic in_item_t rand_item(bit well_formed);
		in_item_t it;
		it.action = well_formed ? 3'($urandom_range(4)) : 3'($urandom_range(7));
		if (well_formed && $urandom_range(9) < 5) it.action = ACT_ENQ;
		it.now_time = ($urandom_range(9) == 0) ? $urandom : 32'(3000 + $urandom_range(400));
		it.job_tag = 16'($urandom);
		it.page_count = 16'($urandom);
		it.job_priority = 2'($urandom);
		it.user_role = ($urandom_range(3) == 0) ? 2'd3 : 2'($urandom_range(2));
		if (well_formed && it.action == ACT_DEL && $urandom_range(3) > 0)
			it.user_role = ROLE_ADMIN;
		it.position = well_formed ? 5'($urandom_range(q_fill_bound())) : 5'($urandom);
		return it;
	endfunction

	function automatic in_item_t mk(action_t a, logic [31:0] t, logic [1:0] p,
			logic [1:0] rl, logic [4:0] pos);
		in_item_t it;
		it.action = a; it.now_time = t; it.job_tag = 16'($urandom);
		it.page_count = 16'($urandom); it.job_priority = p; it.user_role = rl;
		it.position = pos;
		return it;
	endfunction

	task automatic drain();
		while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (NSLOT + 4) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		aging_limit = v;
	endtask

	initial begin
		in_item_t it;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty cases, refusals, extremes, full queue, aging, deletes, unknown actions
		pending_items.push_back(mk(ACT_DEQ, 0, 0, 0, 0));
		pending_items.push_back(mk(ACT_DEL, 0, 0, ROLE_ADMIN, 1));
		pending_items.push_back(mk(ACT_CLR, 0, 0, 0, 0));
		pending_items.push_back(mk(ACT_AGE, 100, 0, 0, 0));
		pending_items.push_back(mk(ACT_ENQ, 5, 0, ROLE_NORMAL, 0));
		for (int i = 0; i < 17; i++) begin
			it = mk(ACT_ENQ, (i == 3) ? 32'hFFFF_FFFF : 32'(i * 10), 2'(3 - i % 4),
				2'(i % 4), 0);
			if (i == 5) begin it.job_tag = 16'hFFFF; it.page_count = 16'hFFFF; end
			if (it.user_role == ROLE_NORMAL && it.job_priority == 0) it.job_priority = 1;
			pending_items.push_back(it);
		end
		pending_items.push_back(mk(ACT_AGE, 200, 0, 0, 0));
		pending_items.push_back(mk(ACT_DEL, 0, 0, 1, 1));
		pending_items.push_back(mk(ACT_DEL, 0, 0, ROLE_ADMIN, 0));
		pending_items.push_back(mk(ACT_DEL, 0, 0, ROLE_ADMIN, 17));
		pending_items.push_back(mk(ACT_DEL, 0, 0, ROLE_ADMIN, 16));
		pending_items.push_back(mk(ACT_DEQ, 0, 0, 0, 0));
		it = mk(ACT_ENQ, 0, 0, 0, 0); it.action = 3'd5;
		pending_items.push_back(it);
		it.action = 3'd7;
		pending_items.push_back(it);
		drain();
		// random phases with different limits and idle rates
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_limit(32'd0);
				1: write_limit(32'hFFFF_FFFF);
				2: write_limit(32'd150);
				3: write_limit(32'd1);
				default: write_limit(32'($urandom_range(400)));
			endcase
			idle_pct = (ph == 1 || ph == 4) ? 59 : (ph == 3 ? 22 : 0);
			for (int n = 0; n < 250; n++) begin
				pending_items.push_back(rand_item($urandom_range(9) > 0));
				if (n == 125) drain();
			end
			drain();
		end
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
